FILE: design/vde_pkg.sv
// Shared types, constants and a helper function for the version directive extractor.
`default_nettype none
package vde_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned VerW      = 16;
  localparam int unsigned TokPosW   = 3;
  localparam int unsigned DigW      = 4;
  localparam int unsigned ProdW     = VerW + 4;
  localparam logic [VerW-1:0] MinVersion = VerW'(100);
  localparam logic [VerW-1:0] MaxVersion = {VerW{1'b1}};

  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChLf    = 8'h0a;
  localparam logic [ChW-1:0] ChVt    = 8'h0b;
  localparam logic [ChW-1:0] ChFf    = 8'h0c;
  localparam logic [ChW-1:0] ChCr    = 8'h0d;
  localparam logic [ChW-1:0] ChSlash = 8'h2f;
  localparam logic [ChW-1:0] ChStar  = 8'h2a;
  localparam logic [ChW-1:0] ChHash  = 8'h23;
  localparam logic [ChW-1:0] ChPlus  = 8'h2b;
  localparam logic [ChW-1:0] ChMinus = 8'h2d;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;

  typedef enum logic [3:0] {
    PH_PLAIN,
    PH_SLASH,
    PH_LINE,
    PH_BLOCK,
    PH_BLOCK_STAR,
    PH_TOKEN,
    PH_NUM_WS,
    PH_NUM_SIGN,
    PH_NUM_DIG,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [ChW-1:0]  ch;
    logic            last;
    logic            blank;
    logic            cspace;
    logic            slash;
    logic            star;
    logic            lf;
    logic            hash;
    logic            plus;
    logic            minus;
    logic            digit;
    logic [DigW-1:0] dval;
  } chr_t;

  function automatic logic [ChW-1:0] token_char(input logic [TokPosW-1:0] pos);
    logic [ChW-1:0] c;
    unique case (pos)
      3'd0: c = ChHash;
      3'd1: c = 8'h76;
      3'd2: c = 8'h65;
      3'd3: c = 8'h72;
      3'd4: c = 8'h73;
      3'd5: c = 8'h69;
      3'd6: c = 8'h6f;
      3'd7: c = 8'h6e;
      default: c = ChHash;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/vde_front.sv
// Front stage: takes input words, classifies each character and holds it for the queue.
`default_nettype none
module vde_front
  import vde_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [ChW-1:0] in_ch,
  input  wire logic           in_last,
  output logic                push,
  output chr_t                push_item,
  input  wire logic           q_full
);

  logic valid_r;
  logic valid_nxt;
  chr_t item_r;
  chr_t item_nxt;

  assign in_stall  = valid_r & q_full;
  assign push      = valid_r & ~q_full;
  assign push_item = item_r;

  always_comb begin
    item_nxt.ch     = in_ch;
    item_nxt.last   = in_last;
    item_nxt.lf     = (in_ch == ChLf);
    item_nxt.blank  = (in_ch == ChSpace) || (in_ch == ChTab) || (in_ch == ChCr) ||
                      (in_ch == ChLf);
    item_nxt.cspace = item_nxt.blank || (in_ch == ChVt) || (in_ch == ChFf);
    item_nxt.slash  = (in_ch == ChSlash);
    item_nxt.star   = (in_ch == ChStar);
    item_nxt.hash   = (in_ch == ChHash);
    item_nxt.plus   = (in_ch == ChPlus);
    item_nxt.minus  = (in_ch == ChMinus);
    item_nxt.digit  = (in_ch >= ChZero) && (in_ch <= ChNine);
    item_nxt.dval   = DigW'(in_ch - ChZero);
    valid_nxt       = in_stall ? valid_r : in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/vde_fifo.sv
// Two-entry queue of classified characters between the front and the back stages.
`default_nettype none
module vde_fifo
  import vde_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire chr_t push_item,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output chr_t      head
);

  chr_t       mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: design/vde_back.sv
// Back stage: runs the scanner on queued characters and holds the result word.
`default_nettype none
module vde_back
  import vde_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire chr_t            head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [VerW-1:0]      out_version,
  output logic                 out_found
);

  phase_t               phase_r;
  phase_t               phase_nxt;
  logic [TokPosW-1:0]   pos_r;
  logic [TokPosW-1:0]   pos_nxt;
  logic                 neg_r;
  logic                 neg_nxt;
  logic [VerW-1:0]      accum_r;
  logic [VerW-1:0]      accum_nxt;
  logic                 got_r;
  logic                 got_nxt;
  logic                 ovalid_r;
  logic                 ovalid_nxt;
  logic [VerW-1:0]      over_r;
  logic [VerW-1:0]      over_nxt;
  logic                 ofound_r;
  logic                 ofound_nxt;
  logic [ProdW-1:0]     prod;
  logic [VerW-1:0]      sat;
  logic                 tok_hit;
  logic                 take_digit;
  phase_t               scan_nxt;

  assign pop         = ~q_empty & (~ovalid_r | ~out_stall);
  assign out_valid   = ovalid_r;
  assign out_version = over_r;
  assign out_found   = ofound_r;

  always_comb begin
    prod = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + {{(ProdW - DigW){1'b0}}, head.dval};
    sat  = (prod > {4'd0, MaxVersion}) ? MaxVersion : prod[VerW-1:0];
    tok_hit = (head.ch == token_char(pos_r));
  end

  always_comb begin
    scan_nxt = phase_r;
    unique case (phase_r)
      PH_PLAIN: begin
        if (head.slash) begin
          scan_nxt = PH_SLASH;
        end else if (!head.blank) begin
          scan_nxt = head.hash ? PH_TOKEN : PH_DONE;
        end
      end
      PH_SLASH: begin
        if (head.slash) begin
          scan_nxt = PH_LINE;
        end else if (head.star) begin
          scan_nxt = PH_BLOCK;
        end else begin
          scan_nxt = PH_DONE;
        end
      end
      PH_LINE: begin
        if (head.lf) begin
          scan_nxt = PH_PLAIN;
        end
      end
      PH_BLOCK: begin
        if (head.star) begin
          scan_nxt = PH_BLOCK_STAR;
        end
      end
      PH_BLOCK_STAR: begin
        if (head.slash) begin
          scan_nxt = PH_PLAIN;
        end else if (!head.star) begin
          scan_nxt = PH_BLOCK;
        end
      end
      PH_TOKEN: begin
        if (!tok_hit) begin
          scan_nxt = PH_DONE;
        end else if (pos_r == {TokPosW{1'b1}}) begin
          scan_nxt = PH_NUM_WS;
        end
      end
      PH_NUM_WS: begin
        if (head.plus || head.minus) begin
          scan_nxt = PH_NUM_SIGN;
        end else if (head.digit) begin
          scan_nxt = PH_NUM_DIG;
        end else if (!head.cspace) begin
          scan_nxt = PH_DONE;
        end
      end
      PH_NUM_SIGN, PH_NUM_DIG: begin
        scan_nxt = head.digit ? PH_NUM_DIG : PH_DONE;
      end
      default: begin
        scan_nxt = PH_DONE;
      end
    endcase
    phase_nxt = phase_r;
    if (pop) begin
      phase_nxt = head.last ? PH_PLAIN : scan_nxt;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    neg_nxt    = neg_r;
    accum_nxt  = accum_r;
    got_nxt    = got_r;
    ovalid_nxt = ovalid_r & out_stall;
    over_nxt   = over_r;
    ofound_nxt = ofound_r;
    take_digit = head.digit && ((phase_r == PH_NUM_WS) || (phase_r == PH_NUM_SIGN) ||
                                (phase_r == PH_NUM_DIG));
    if (pop) begin
      if ((phase_r == PH_PLAIN) && head.hash) begin
        pos_nxt = TokPosW'(1);
      end
      if ((phase_r == PH_TOKEN) && tok_hit) begin
        pos_nxt = pos_r + TokPosW'(1);
      end
      if ((phase_r == PH_NUM_WS) && head.minus) begin
        neg_nxt = 1'b1;
      end
      if (take_digit) begin
        accum_nxt = sat;
        got_nxt   = 1'b1;
      end
      if (head.last) begin
        ovalid_nxt = 1'b1;
        ofound_nxt = got_nxt;
        over_nxt   = (got_nxt && !neg_nxt && (accum_nxt > MinVersion)) ? accum_nxt : MinVersion;
        pos_nxt    = '0;
        neg_nxt    = 1'b0;
        accum_nxt  = '0;
        got_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PLAIN;
      pos_r    <= '0;
      neg_r    <= 1'b0;
      accum_r  <= '0;
      got_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      neg_r    <= neg_nxt;
      accum_r  <= accum_nxt;
      got_r    <= got_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    over_r   <= over_nxt;
    ofound_r <= ofound_nxt;
  end

endmodule
`default_nettype wire

FILE: design/version_directive_extractor_unit.sv
// Top level of the version directive extractor: front stage, queue and back stage.
//
// The input channel carries one source character per word (in_ch) and a flag,
// in_last, that marks the final character of a text. The result channel carries
// one word per text, on its last character: out_found tells whether a version
// directive with a number was parsed, and out_version gives the larger of 100
// and that number, saturated at 65535.
// A character is classified in the front stage, waits in a two-entry queue and
// is then scanned by the back stage, which updates the scanner state and the
// running number with one multiply-by-ten add per character.
// A last character passes the front-stage register and the queue before the
// back stage registers the result word. Throughput: one character per cycle
// while no result word is stalled, set by the single back-stage scanner update.
// When the receiver stalls, the result word is held and the queue fills; the
// input is stalled only once the queue and the front stage are both full.
// Reset clears the scanner to plain text, empties the queue and drops any
// pending result word.
`default_nettype none
module version_directive_extractor_unit
  import vde_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [ChW-1:0]  in_ch,
  input  wire logic            in_last,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [VerW-1:0]      out_version,
  output logic                 out_found
);

  logic push;
  chr_t push_item;
  logic q_full;
  logic pop;
  logic q_empty;
  chr_t head;

  vde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_last   (in_last),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  vde_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  vde_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_version (out_version),
    .out_found   (out_found)
  );

endmodule
`default_nettype wire

FILE: design/vde_checker.sv
// Port-level checker for the version directive extractor and its bind statement.
`default_nettype none
module vde_checker
  import vde_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic [ChW-1:0]  in_ch,
  input wire logic            in_last,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire logic [VerW-1:0] out_version,
  input wire logic            out_found
);

  // A result word never reports less than the minimum version.
  a_ver_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_version >= MinVersion))
    else $error("version below minimum");

  // Without a parsed number the version is the minimum.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_version == MinVersion))
    else $error("version set without a number");

  // No result word is shown straight after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_version) && $stable(out_found)))
    else $error("stalled result word changed");

  // A stalled input word is offered again unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_ch) && $stable(in_last)))
    else $error("stalled input word changed");

endmodule

bind version_directive_extractor_unit vde_checker u_vde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_ch       (in_ch),
  .in_last     (in_last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_version (out_version),
  .out_found   (out_found)
);
`default_nettype wire
